// File: rtl/core/assert_macros.svh
// Assertion macros for the RTL of the comment and body stripper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// File: rtl/core/ccs_pkg.sv
// Package with the types and character codes of the comment and body stripper.
`timescale 1ns / 1ps
`default_nettype none

package ccs_pkg;

    // Default width of the brace depth counter.
    localparam int CCS_DEPTH_BITS = 8;

    // Characters that steer the parser.
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_OPEN  = 8'h7B;
    localparam logic [7:0] CH_CLOSE = 8'h7D;
    localparam logic [7:0] CH_NL    = 8'h0A;

    // Parser modes, one-hot.
    typedef enum logic [6:0] {
        MODE_NORMAL     = 7'b0000001,
        MODE_SLASH      = 7'b0000010,
        MODE_LINE       = 7'b0000100,
        MODE_BLOCK      = 7'b0001000,
        MODE_BLOCK_STAR = 7'b0010000,
        MODE_SKIP_LINE  = 7'b0100000,
        MODE_BODY       = 7'b1000000
    } mode_t;

    // One result beat.
    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
    } res_t;

    // Number of result beats caused by one input beat (0, 1 or 2).
    typedef logic [1:0] res_cnt_t;

endpackage

`default_nettype wire

// File: rtl/core/c_comment_and_body_stripper_top.sv
// Top level of the comment and body stripper: parser state and result queue.
//
// Filters C source text at one byte per clock while in_stall is low: line
// comments, block comments with the rest of their line, and everything inside
// brace-delimited bodies are dropped, while the outer braces are kept. A beat
// with text_end high flushes a pending slash and produces an end beat with last
// high. The parser state is updated in the cycle a beat is accepted, and its
// results appear on the output from the next cycle through a four-entry result
// queue. A byte normally causes zero or one result; a lone slash followed by a
// byte, or a pending slash at end of text, causes two. in_stall rises while more
// than two results wait in the queue, so with the output never stalled the block
// takes one input beat every cycle and sustains one result beat per cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module c_comment_and_body_stripper_top #(
    parameter int DEPTH_BITS = ccs_pkg::CCS_DEPTH_BITS
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_stall,
    input  wire [7:0]  in_byte,
    input  wire        text_end,
    output logic       out_valid,
    input  wire        out_stall,
    output logic [7:0] out_byte,
    output logic       byte_present,
    output logic       last
);
    import ccs_pkg::*;

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PTR_BITS-1:0] PTR_ONE     = PTR_BITS'(1);
    localparam logic [CNT_BITS-1:0] CNT_LIMIT   = CNT_BITS'(QUEUE_DEPTH - 2);
    localparam logic [CNT_BITS-1:0] CNT_FULL    = CNT_BITS'(QUEUE_DEPTH);

    // Parser state.
    mode_t                 mode_reg;
    mode_t                 mode_next;
    logic [DEPTH_BITS-1:0] depth_reg;
    logic [DEPTH_BITS-1:0] depth_next;

    // Result queue.
    res_t                  queue_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;
    logic [PTR_BITS-1:0]   wr_ptr_plus1;

    res_t                  res0;
    res_t                  res1;
    res_cnt_t              res_cnt;
    res_cnt_t              push_n;
    logic                  in_fire;
    logic                  pop;
    res_t                  head;

    // Byte parser.
    ccs_step #(
        .DEPTH_BITS (DEPTH_BITS)
    ) u_step (
        .mode       (mode_reg),
        .depth      (depth_reg),
        .in_byte    (in_byte),
        .text_end   (text_end),
        .mode_next  (mode_next),
        .depth_next (depth_next),
        .res0       (res0),
        .res1       (res1),
        .res_cnt    (res_cnt)
    );

    // Handshake on both sides.
    assign in_stall  = (count_reg > CNT_LIMIT);
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign push_n    = in_fire ? res_cnt : 2'd0;

    // Queue pointers and fill count.
    assign wr_ptr_plus1 = wr_ptr_reg + PTR_ONE;
    assign wr_ptr_next  = wr_ptr_reg + PTR_BITS'(push_n);
    assign rd_ptr_next  = pop ? (rd_ptr_reg + PTR_ONE) : rd_ptr_reg;
    assign count_next   = count_reg + CNT_BITS'(push_n) - CNT_BITS'(pop);

    // Parser state and queue control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_NORMAL;
            depth_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                mode_reg  <= mode_next;
                depth_reg <= depth_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue entries: the first result goes to the write pointer, a second one after it.
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2)
        begin
            queue_reg[wr_ptr_plus1] <= res1;
        end
    end

    // Output beat from the head of the queue.
    assign head         = queue_reg[rd_ptr_reg];
    assign out_byte     = head.data;
    assign byte_present = head.present;
    assign last         = head.last;

    // Checks on the queue and the parser.
    `ASSERT_NEVER(a_count_over, clk, rst_n, count_reg > CNT_FULL, "result queue overfilled")
    `ASSERT_CLK(a_ptr_count, clk, rst_n, (PTR_BITS'(wr_ptr_reg - rd_ptr_reg) == PTR_BITS'(count_reg)) || (count_reg == CNT_FULL), "queue pointers disagree with fill count")
    `ASSERT_CLK(a_end_resets, clk, rst_n, (in_fire && text_end) |=> ((mode_reg == MODE_NORMAL) && (depth_reg == '0)), "end of text did not reset the parser")
    `ASSERT_NEVER(a_body_depth, clk, rst_n, (mode_reg == MODE_BODY) && (depth_reg == '0), "inside a body with zero depth")

endmodule

`default_nettype wire

// File: rtl/core/ccs_step.sv
// Next-state and result logic of the stripper for one input byte.
`timescale 1ns / 1ps
`default_nettype none

module ccs_step #(
    parameter int DEPTH_BITS = 8
) (
    input  wire ccs_pkg::mode_t    mode,
    input  wire [DEPTH_BITS-1:0]   depth,
    input  wire [7:0]              in_byte,
    input  wire                    text_end,
    output ccs_pkg::mode_t         mode_next,
    output logic [DEPTH_BITS-1:0]  depth_next,
    output ccs_pkg::res_t          res0,
    output ccs_pkg::res_t          res1,
    output ccs_pkg::res_cnt_t      res_cnt
);
    import ccs_pkg::*;

    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX  = {DEPTH_BITS{1'b1}};
    localparam logic [DEPTH_BITS-1:0] DEPTH_ONE  = DEPTH_BITS'(1);
    localparam logic [DEPTH_BITS-1:0] DEPTH_ZERO = '0;

    // Handling of a byte in normal text: a slash is held back, a brace opens a body.
    mode_t                 nb_mode;
    logic [DEPTH_BITS-1:0] nb_depth;
    logic                  nb_emit;
    res_t                  nb_res;
    res_t                  slash_res;
    res_t                  end_res;

    always_comb
    begin
        nb_res   = '{data: in_byte, present: 1'b1, last: 1'b0};
        nb_emit  = 1'b1;
        nb_depth = depth;
        nb_mode  = MODE_NORMAL;
        if (in_byte == CH_SLASH)
        begin
            nb_emit = 1'b0;
            nb_mode = MODE_SLASH;
        end
        else if (in_byte == CH_OPEN)
        begin
            nb_depth = DEPTH_ONE;
            nb_mode  = MODE_BODY;
        end
    end

    assign slash_res = '{data: CH_SLASH, present: 1'b1, last: 1'b0};
    assign end_res   = '{data: 8'h00, present: 1'b0, last: 1'b1};

    // Mode and depth update, and the result beats of this byte.
    always_comb
    begin
        mode_next  = mode;
        depth_next = depth;
        res0       = '0;
        res1       = '0;
        res_cnt    = 2'd0;
        if (text_end)
        begin
            // End of text: flush a pending slash, then the end beat.
            mode_next  = MODE_NORMAL;
            depth_next = DEPTH_ZERO;
            if (mode == MODE_SLASH)
            begin
                res0    = slash_res;
                res1    = end_res;
                res_cnt = 2'd2;
            end
            else
            begin
                res0    = end_res;
                res_cnt = 2'd1;
            end
        end
        else
        begin
            case (mode)
                MODE_SLASH:
                begin
                    if (in_byte == CH_SLASH)
                    begin
                        mode_next = MODE_LINE;
                    end
                    else if (in_byte == CH_STAR)
                    begin
                        mode_next = MODE_BLOCK;
                    end
                    else
                    begin
                        // Lone slash: emit it, then treat this byte as normal text.
                        res0       = slash_res;
                        res1       = nb_res;
                        res_cnt    = nb_emit ? 2'd2 : 2'd1;
                        mode_next  = nb_mode;
                        depth_next = nb_depth;
                    end
                end
                MODE_LINE:
                begin
                    if (in_byte == CH_NL)
                    begin
                        mode_next = MODE_NORMAL;
                    end
                end
                MODE_BLOCK:
                begin
                    if (in_byte == CH_STAR)
                    begin
                        mode_next = MODE_BLOCK_STAR;
                    end
                end
                MODE_BLOCK_STAR:
                begin
                    if (in_byte == CH_SLASH)
                    begin
                        mode_next = MODE_SKIP_LINE;
                    end
                    else if (in_byte != CH_STAR)
                    begin
                        mode_next = MODE_BLOCK;
                    end
                end
                MODE_SKIP_LINE:
                begin
                    if (in_byte == CH_NL)
                    begin
                        mode_next = MODE_NORMAL;
                    end
                end
                MODE_BODY:
                begin
                    if (in_byte == CH_OPEN)
                    begin
                        if (depth != DEPTH_MAX)
                        begin
                            depth_next = depth + DEPTH_ONE;
                        end
                    end
                    else if (in_byte == CH_CLOSE)
                    begin
                        if (depth[DEPTH_BITS-1:1] == '0)
                        begin
                            // Outermost closing brace: keep it and leave the body.
                            depth_next = DEPTH_ZERO;
                            res0       = '{data: CH_CLOSE, present: 1'b1, last: 1'b0};
                            res_cnt    = 2'd1;
                            mode_next  = MODE_NORMAL;
                        end
                        else
                        begin
                            depth_next = depth - DEPTH_ONE;
                        end
                    end
                end
                default:
                begin
                    // Normal text, and any code that is not a mode.
                    res0       = nb_res;
                    res_cnt    = nb_emit ? 2'd1 : 2'd0;
                    mode_next  = nb_mode;
                    depth_next = nb_depth;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
